// ===== rtl/brld_pkg.sv =====
package brld_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned RUN_W     = 7;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned NEED_W    = 4;

  typedef struct packed {
    logic load;
    logic emit;
    logic absorb;
    logic emit_bad;
  } cmd_t;

  typedef struct packed {
    logic zero_run;
    logic fits;
    logic exact;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/brld_if.sv =====
interface brld_in_if;
  logic                          valid;
  logic                          ready;
  logic [brld_pkg::CODE_W-1:0]   run_code;

  modport source (output valid, output run_code, input ready);
  modport sink (input valid, input run_code, output ready);
endinterface

interface brld_out_if;
  logic                          valid;
  logic                          ready;
  logic [brld_pkg::BYTE_BITS-1:0] out_byte;
  logic                          last_of_run;
  logic                          bad_code;

  modport source (output valid, output out_byte, output last_of_run, output bad_code,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input bad_code,
                output ready);
endinterface

// ===== rtl/bit_run_length_decoder.sv =====
// Bit run-length decoder.
// The input channel carries one run code per transfer: bit 7 is the bit
// value and bits 6..0 the run length. The decoder appends that many copies
// of the bit to a pending byte, filled from the most significant bit down,
// and sends each completed byte on the output channel. The last byte caused
// by a code has last_of_run set. A code with a zero run length gives a
// single result with bad_code and last_of_run set and a zero byte, and
// leaves the pending byte alone. A trailing partial byte stays pending.
// One code is handled at a time: the code is taken, then one byte is
// produced per cycle while the receiver accepts, and bits left over are
// added to the pending byte as the last step. The first byte is written
// to the output register from the run state, after the code is loaded.
// When the receiver stalls, the result is held in the output register and
// the byte loop waits; the next code is taken once the current one is done.
// Synchronous reset clears the pending byte and the output valid, and
// returns the control to idle, where the input ready is high.
module bit_run_length_decoder (
  input  logic        clk,
  input  logic        rst,
  brld_in_if.sink     in,
  brld_out_if.source  out
);

  brld_pkg::cmd_t cmd;
  brld_pkg::sts_t sts;

  brld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brld_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .run_code    (in.run_code),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_byte    (out.out_byte),
    .last_of_run (out.last_of_run),
    .bad_code    (out.bad_code)
  );

endmodule

// ===== rtl/brld_ctrl.sv =====
module brld_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  brld_pkg::sts_t   sts,
  output brld_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_BAD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.zero_run ? S_BAD : S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.fits) begin
          cmd.absorb = 1'b1;
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.exact) begin
            state_next = S_IDLE;
          end
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.emit_bad = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.emit, cmd.absorb, cmd.emit_bad}))
    else $error("More than one datapath command in a cycle.");

  a_bad_path: assert property (@(posedge clk) disable iff (rst)
    cmd.load && sts.zero_run |=> state == S_BAD)
    else $error("Zero-length run did not take the error path.");
`endif

endmodule

// ===== rtl/brld_dp.sv =====
module brld_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [brld_pkg::CODE_W-1:0]       run_code,
  input  brld_pkg::cmd_t                    cmd,
  output brld_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [brld_pkg::BYTE_BITS-1:0]    out_byte,
  output logic                              last_of_run,
  output logic                              bad_code
);

  logic                              run_bit;
  logic [brld_pkg::RUN_W-1:0]        remaining;
  logic [brld_pkg::BYTE_BITS-1:0]    pending_bits;
  logic [brld_pkg::CNT_W-1:0]        pending_count;

  logic [brld_pkg::NEED_W-1:0]       need;
  logic [brld_pkg::RUN_W-1:0]        rem_after;
  logic [brld_pkg::NEED_W-1:0]       part_end;
  logic [brld_pkg::BYTE_BITS-1:0]    fill_mask;
  logic [brld_pkg::BYTE_BITS-1:0]    part_mask;
  logic [brld_pkg::BYTE_BITS-1:0]    full_byte;

  assign need      = brld_pkg::NEED_W'(brld_pkg::BYTE_BITS) - {1'b0, pending_count};
  assign rem_after = remaining - brld_pkg::RUN_W'(need);
  assign part_end  = {1'b0, pending_count} + {1'b0, remaining[brld_pkg::CNT_W-1:0]};
  assign fill_mask = {brld_pkg::BYTE_BITS{1'b1}} >> pending_count;
  assign part_mask = fill_mask & ~({brld_pkg::BYTE_BITS{1'b1}} >> part_end);
  assign full_byte = run_bit ? (pending_bits | fill_mask) : pending_bits;

  assign sts.zero_run = (run_code[brld_pkg::RUN_W-1:0] == '0);
  assign sts.fits     = (brld_pkg::RUN_W'(need) <= remaining);
  assign sts.exact    = (rem_after == '0);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      run_bit   <= run_code[brld_pkg::CODE_W-1];
      remaining <= run_code[brld_pkg::RUN_W-1:0];
    end else if (cmd.emit) begin
      remaining <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (cmd.emit) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (cmd.absorb) begin
      if (run_bit) begin
        pending_bits <= pending_bits | part_mask;
      end
      pending_count <= part_end[brld_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_bad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte    <= full_byte;
      last_of_run <= (rem_after[brld_pkg::RUN_W-1:brld_pkg::CNT_W] == '0);
      bad_code    <= 1'b0;
    end else if (cmd.emit_bad) begin
      out_byte    <= '0;
      last_of_run <= 1'b1;
      bad_code    <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_bad) |-> sts.out_free)
    else $error("Result written over one not yet transferred.");

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_code |-> out_byte == '0 && last_of_run)
    else $error("Error result carries a byte or is not last.");

  a_bad_keeps: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_bad |=> pending_count == $past(pending_count)
                     && pending_bits == $past(pending_bits))
    else $error("Zero-length run changed the pending byte.");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> pending_count == '0 && pending_bits == '0)
    else $error("Pending byte not cleared after a completed byte.");
`endif

endmodule
